// File: sv/clr_pkg.sv
`default_nettype none
package clr_pkg;

   // Field widths of the request and response channels.
   localparam int unsigned COORD_W = 16;
   localparam int unsigned INK_W   = 8;
   localparam int unsigned PIX_W   = 6;
   localparam int unsigned ADDR_W  = 14;

   // Internal walk widths: coordinates carry one guard bit, deltas and the
   // error term are wide enough for the full 16-bit span.
   localparam int unsigned POS_W   = COORD_W + 1;
   localparam int unsigned DELTA_W = COORD_W + 2;
   localparam int unsigned ERR_W   = COORD_W + 4;

   // Configuration registers.
   localparam int unsigned WIDTH_W  = 7;
   localparam int unsigned HEIGHT_W = 7;
   localparam int unsigned STRIDE_W = 9;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_STRIDE    = 2'd2;

   localparam logic [WIDTH_W-1:0]  RST_SCREEN_WIDTH  = 7'd64;
   localparam logic [HEIGHT_W-1:0] RST_SCREEN_HEIGHT = 7'd64;
   localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE    = 9'd64;

   localparam int unsigned DEF_MAX_WIDTH  = 64;
   localparam int unsigned DEF_MAX_HEIGHT = 64;

   // At most this many pixel writes per line command.
   localparam int unsigned RESULT_CAP = 64;
   localparam int unsigned CNT_W      = $clog2(RESULT_CAP + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_FLUSH
   } state_type;

   // Controls from the sequencer to the line walker.
   typedef struct packed {
      logic load;
      logic prime;
      logic step;
   } walk_ctl_type;

   // Current point of the walk.
   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic                    at_end;
   } walk_pos_type;

endpackage
`default_nettype wire

// File: sv/clr_walker.sv
`default_nettype none
module clr_walker (
   input  wire                                  clock,
   input  wire clr_pkg::walk_ctl_type           ctl,
   input  wire logic signed [clr_pkg::COORD_W-1:0] x_start,
   input  wire logic signed [clr_pkg::COORD_W-1:0] y_start,
   input  wire logic signed [clr_pkg::COORD_W-1:0] x_end,
   input  wire logic signed [clr_pkg::COORD_W-1:0] y_end,
   output clr_pkg::walk_pos_type                pos
);

   logic signed [clr_pkg::POS_W-1:0]   x_ff, y_ff, xe_ff, ye_ff;
   logic signed [clr_pkg::DELTA_W-1:0] dx_ff, dy_ff;
   logic signed [clr_pkg::ERR_W-1:0]   err_ff;
   logic                               sx_neg_ff, sy_neg_ff;

   logic signed [clr_pkg::DELTA_W-1:0] diff_x, diff_y, adx, ady;
   logic signed [clr_pkg::ERR_W-1:0]   dx_ext, dy_ext;
   logic signed [clr_pkg::ERR_W:0]     e2;
   logic                               step_x, step_y;
   logic signed [clr_pkg::ERR_W-1:0]   err_in;
   logic signed [clr_pkg::POS_W-1:0]   x_in, y_in;

   always_comb begin
      diff_x = clr_pkg::DELTA_W'(x_end) - clr_pkg::DELTA_W'(x_start);
      diff_y = clr_pkg::DELTA_W'(y_end) - clr_pkg::DELTA_W'(y_start);
      adx    = diff_x[clr_pkg::DELTA_W-1] ? -diff_x : diff_x;
      ady    = diff_y[clr_pkg::DELTA_W-1] ? -diff_y : diff_y;

      dx_ext = clr_pkg::ERR_W'(dx_ff);
      dy_ext = clr_pkg::ERR_W'(dy_ff);

      // Doubled error decides which axes advance on this step.
      e2     = {err_ff, 1'b0};
      step_x = e2 >= (clr_pkg::ERR_W + 1)'(dy_ff);
      step_y = e2 <= (clr_pkg::ERR_W + 1)'(dx_ff);

      err_in = err_ff + (step_x ? dy_ext : '0) + (step_y ? dx_ext : '0);
      x_in   = x_ff;
      y_in   = y_ff;
      if (step_x) begin
         x_in = sx_neg_ff ? x_ff - clr_pkg::POS_W'(1) : x_ff + clr_pkg::POS_W'(1);
      end
      if (step_y) begin
         y_in = sy_neg_ff ? y_ff - clr_pkg::POS_W'(1) : y_ff + clr_pkg::POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_ff      <= clr_pkg::POS_W'(x_start);
         y_ff      <= clr_pkg::POS_W'(y_start);
         xe_ff     <= clr_pkg::POS_W'(x_end);
         ye_ff     <= clr_pkg::POS_W'(y_end);
         dx_ff     <= adx;
         dy_ff     <= -ady;
         sx_neg_ff <= diff_x[clr_pkg::DELTA_W-1] || (diff_x == '0);
         sy_neg_ff <= diff_y[clr_pkg::DELTA_W-1] || (diff_y == '0);
      end
      if (ctl.prime) begin
         err_ff <= dx_ext + dy_ext;
      end
      if (ctl.step) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         err_ff <= err_in;
      end
   end

   assign pos.x      = x_ff;
   assign pos.y      = y_ff;
   assign pos.at_end = (x_ff == xe_ff) && (y_ff == ye_ff);

endmodule
`default_nettype wire

// File: sv/clipped_line_rasterizer.sv
// Clipped line rasterizer.
// A request carries two signed 16-bit endpoints, an ink value and a flag
// that says whether the end point is drawn. The block walks the line with
// the Bresenham error term, one point per clock unless the walk pauses for
// the output, and sends a response for every point that falls inside the
// configured screen, with its column, row, buffer address (row times stride
// plus column) and ink. The final response of a request has last set; a
// request with no visible point gives a single response with write_enable
// low and last set. After acceptance a setup state primes the error term,
// then the walk state visits each point of the line (the line's longer
// axis span, plus one), then a flush state hands over the final response.
// No new request is accepted until then. Off-screen points are walked as
// well, so a long line that leaves the screen takes correspondingly longer.
// req_stall stays high from acceptance until the final response has entered
// the output register. One visible point waits in a hold register; when
// rsp_stall keeps a response in the output register, the walk pauses at the
// next visible point until the output register is free.
// Configuration registers are written through the csr_ port; the user must
// write them only while idle, which the block itself does not enforce.
// Reset is synchronous; it empties the block and restores the registers.
`default_nettype none
module clipped_line_rasterizer #(
   parameter int unsigned MAX_WIDTH  = clr_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = clr_pkg::DEF_MAX_HEIGHT
) (
   input  wire                                    clock,
   input  wire                                    reset,

   input  wire                                    csr_write_enable,
   input  wire logic [clr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [clr_pkg::CSR_DATA_W-1:0]    csr_write_data,

   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire logic signed [clr_pkg::COORD_W-1:0] req_x_start,
   input  wire logic signed [clr_pkg::COORD_W-1:0] req_y_start,
   input  wire logic signed [clr_pkg::COORD_W-1:0] req_x_end,
   input  wire logic signed [clr_pkg::COORD_W-1:0] req_y_end,
   input  wire logic [clr_pkg::INK_W-1:0]         req_ink,
   input  wire                                    req_include_end,

   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic [clr_pkg::PIX_W-1:0]              rsp_pixel_x,
   output logic [clr_pkg::PIX_W-1:0]              rsp_pixel_y,
   output logic [clr_pkg::ADDR_W-1:0]             rsp_pixel_addr,
   output logic [clr_pkg::INK_W-1:0]              rsp_pixel_value,
   output logic                                   rsp_write_enable,
   output logic                                   rsp_last
);

   localparam logic [clr_pkg::WIDTH_W-1:0]  MaxW = clr_pkg::WIDTH_W'(MAX_WIDTH);
   localparam logic [clr_pkg::HEIGHT_W-1:0] MaxH = clr_pkg::HEIGHT_W'(MAX_HEIGHT);
   localparam int unsigned PROD_W = clr_pkg::PIX_W + clr_pkg::STRIDE_W;

   // Configuration registers.
   logic [clr_pkg::WIDTH_W-1:0]  screen_width_ff;
   logic [clr_pkg::HEIGHT_W-1:0] screen_height_ff;
   logic [clr_pkg::STRIDE_W-1:0] row_stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= clr_pkg::RST_SCREEN_WIDTH;
         screen_height_ff <= clr_pkg::RST_SCREEN_HEIGHT;
         row_stride_ff    <= clr_pkg::RST_ROW_STRIDE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            clr_pkg::REG_SCREEN_WIDTH: begin
               screen_width_ff <= csr_write_data[clr_pkg::WIDTH_W-1:0];
            end
            clr_pkg::REG_SCREEN_HEIGHT: begin
               screen_height_ff <= csr_write_data[clr_pkg::HEIGHT_W-1:0];
            end
            clr_pkg::REG_ROW_STRIDE: begin
               row_stride_ff <= csr_write_data[clr_pkg::STRIDE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer and datapath registers.
   clr_pkg::state_type state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        held_valid_ff, held_valid_in;
   logic [clr_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [clr_pkg::PIX_W-1:0]   held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic [clr_pkg::INK_W-1:0]   ink_ff;
   logic                        incl_ff;
   logic [clr_pkg::PIX_W-1:0]   out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [clr_pkg::ADDR_W-1:0]  out_addr_ff, out_addr_in;
   logic [clr_pkg::INK_W-1:0]   out_value_ff, out_value_in;
   logic                        out_we_ff, out_we_in, out_last_ff, out_last_in;

   clr_pkg::walk_ctl_type ctl;
   clr_pkg::walk_pos_type pos;

   logic                              req_take, out_free, visible, on_screen;
   logic [clr_pkg::WIDTH_W-1:0]       w_eff;
   logic [clr_pkg::HEIGHT_W-1:0]      h_eff;
   logic [PROD_W-1:0]                 held_addr;

   clr_walker u_walker (
      .clock   (clock),
      .ctl     (ctl),
      .x_start (req_x_start),
      .y_start (req_y_start),
      .x_end   (req_x_end),
      .y_end   (req_y_end),
      .pos     (pos)
   );

   always_comb begin
      w_eff = (screen_width_ff > MaxW) ? MaxW : screen_width_ff;
      h_eff = (screen_height_ff > MaxH) ? MaxH : screen_height_ff;

      on_screen = !pos.x[clr_pkg::POS_W-1] && !pos.y[clr_pkg::POS_W-1]
                  && (pos.x[clr_pkg::COORD_W-1:0] < clr_pkg::COORD_W'(w_eff))
                  && (pos.y[clr_pkg::COORD_W-1:0] < clr_pkg::COORD_W'(h_eff));
      // The end point counts only when it is to be drawn.
      visible = on_screen && (count_ff < clr_pkg::CNT_W'(clr_pkg::RESULT_CAP))
                && !(pos.at_end && !incl_ff);

      held_addr = PROD_W'(held_y_ff) * PROD_W'(row_stride_ff) + PROD_W'(held_x_ff);

      out_free = !rsp_valid_ff || !rsp_stall;
      req_take = req_valid && (state_ff == clr_pkg::ST_IDLE);

      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      held_valid_in = held_valid_ff;
      count_in      = count_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_addr_in   = out_addr_ff;
      out_value_in  = out_value_ff;
      out_we_in     = out_we_ff;
      out_last_in   = out_last_ff;
      ctl           = '0;

      unique case (state_ff)
         clr_pkg::ST_IDLE: begin
            if (req_take) begin
               ctl.load      = 1'b1;
               held_valid_in = 1'b0;
               count_in      = '0;
               state_in      = clr_pkg::ST_SETUP;
            end
         end
         clr_pkg::ST_SETUP: begin
            ctl.prime = 1'b1;
            state_in  = clr_pkg::ST_WALK;
         end
         clr_pkg::ST_WALK: begin
            // A new visible point pushes the held one out, which needs room.
            if (!(visible && held_valid_ff && !out_free)) begin
               if (visible) begin
                  if (held_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     out_x_in     = held_x_ff;
                     out_y_in     = held_y_ff;
                     out_addr_in  = held_addr[clr_pkg::ADDR_W-1:0];
                     out_value_in = ink_ff;
                     out_we_in    = 1'b1;
                     out_last_in  = 1'b0;
                  end
                  held_valid_in = 1'b1;
                  held_x_in     = pos.x[clr_pkg::PIX_W-1:0];
                  held_y_in     = pos.y[clr_pkg::PIX_W-1:0];
                  count_in      = count_ff + 1'b1;
               end
               if (pos.at_end) begin
                  state_in = clr_pkg::ST_FLUSH;
               end else begin
                  ctl.step = 1'b1;
               end
            end
         end
         clr_pkg::ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_last_in   = 1'b1;
               out_we_in     = held_valid_ff;
               if (held_valid_ff) begin
                  out_x_in     = held_x_ff;
                  out_y_in     = held_y_ff;
                  out_addr_in  = held_addr[clr_pkg::ADDR_W-1:0];
                  out_value_in = ink_ff;
               end else begin
                  out_x_in     = '0;
                  out_y_in     = '0;
                  out_addr_in  = '0;
                  out_value_in = '0;
               end
               held_valid_in = 1'b0;
               state_in      = clr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = clr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= clr_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ink_ff  <= req_ink;
         incl_ff <= req_include_end;
      end
      held_x_ff    <= held_x_in;
      held_y_ff    <= held_y_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_addr_ff  <= out_addr_in;
      out_value_ff <= out_value_in;
      out_we_ff    <= out_we_in;
      out_last_ff  <= out_last_in;
   end

   assign req_stall        = (state_ff != clr_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = out_x_ff;
   assign rsp_pixel_y      = out_y_ff;
   assign rsp_pixel_addr   = out_addr_ff;
   assign rsp_pixel_value  = out_value_ff;
   assign rsp_write_enable = out_we_ff;
   assign rsp_last         = out_last_ff;

endmodule
`default_nettype wire
